// ===== rtl/psm_pkg.sv =====
// ============================================================================
// psm_pkg: shared types and constants of the packed spectrum multiplier
// Holds field widths, the fixed-point format, the result queue size, the
// register index codes and the record types passed between pipeline stages.
// ============================================================================
package psm_pkg;

  localparam int DATA_W     = 32;            // Q16.16 sample width
  localparam int FRAC_BITS  = 16;            // fraction bits of the Q format
  localparam int COORD_W    = 12;            // row / column counter width
  localparam int DIM_W      = 13;            // frame dimension register width
  localparam int MAX_DIM    = 4096;          // largest usable dimension
  localparam int NEG_W      = DATA_W + 1;    // B imaginary part after negation
  localparam int PROD_W     = DATA_W + NEG_W; // one exact product
  localparam int SUM_W      = PROD_W + 2;    // exact sum of two products
  localparam int FIFO_DEPTH = 8;             // result queue entries
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 5);
  localparam int CFG_IDX_W  = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FRAME_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_FRAME_HEIGHT = cfg_idx_t'(1);
  localparam cfg_idx_t REG_CONJUGATE_B  = cfg_idx_t'(2);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1920);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(1080);

  // what one stage slot carries: nothing, one lone real product, or a pair
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LONE,
    KIND_PAIR
  } kind_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } elem_t;

  typedef struct packed {
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic signed [DATA_W-1:0] value;
    logic                     run_last;
    logic                     frame_done;
  } result_t;

  function automatic logic [1:0] kind_count(input kind_t k);
    logic [1:0] n;
    case (k)
      KIND_LONE: n = 2'd1;
      KIND_PAIR: n = 2'd2;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/packed_spectrum_multiply.sv =====
// ============================================================================
// packed_spectrum_multiply: element-wise product of two packed real spectra
// Walks a packed (CCS) spectrum in raster order, pairs re/im elements of
// edge columns vertically and of interior columns horizontally, and emits
// the saturated Q16.16 complex products with their row and column.
// ============================================================================
//
//  channel | dir | handshake             | payload ports
//  --------+-----+-----------------------+------------------------------------------
//  in      | in  | in_valid / in_stall   | in_a_value, in_b_value
//  out     | out | out_valid / out_stall | out_{row,col,product_value,run_last,frame_done}
//  cfg     | in  | cfg_we                | cfg_index, cfg_wdata
//
//  One beat is taken per cycle while in_stall is low. A beat's results pass
//  from the operand register, loaded at the edge that takes the beat, to the
//  product register and are then written to the result queue.
//  The rate is set by the result queue: in_stall rises only when the queue
//  plus the results still in flight could leave fewer than two free entries.
//  Reset (rst_n low, synchronous) restarts the raster at row 0, column 0,
//  loads 1920 x 1080 with conjugation on and empties pipeline and queue.
//  A stalled output holds the head of the queue; the pipeline never stops.
//
module packed_spectrum_multiply (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beats
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [psm_pkg::DATA_W-1:0]   in_a_value,
  input  logic signed [psm_pkg::DATA_W-1:0]   in_b_value,
  // result beats
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [psm_pkg::COORD_W-1:0]         out_row,
  output logic [psm_pkg::COORD_W-1:0]         out_col,
  output logic signed [psm_pkg::DATA_W-1:0]   out_product_value,
  output logic                                out_run_last,
  output logic                                out_frame_done,
  // configuration writes
  input  logic                                cfg_we,
  input  psm_pkg::cfg_idx_t                   cfg_index,
  input  logic [psm_pkg::DIM_W-1:0]           cfg_wdata
);

  import psm_pkg::*;

  localparam logic signed [SUM_W-1:0] Q_MAX = SUM_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] Q_MIN = -Q_MAX - SUM_W'(1);

  // shift the exact sum down to Q16.16 (floor) and clamp to the 32-bit range
  function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] s;
    logic signed [DATA_W-1:0] r;
    s = x >>> FRAC_BITS;
    if (s > Q_MAX) begin
      r = Q_MAX[DATA_W-1:0];
    end else if (s < Q_MIN) begin
      r = Q_MIN[DATA_W-1:0];
    end else begin
      r = s[DATA_W-1:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration and raster position
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]   width_r, width_nxt;
  logic [DIM_W-1:0]   height_r, height_nxt;
  logic               conj_r, conj_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;

  logic [DIM_W-1:0]   w_eff, h_eff;
  logic               accept;
  logic               last_col, last_row;

  // a zero dimension acts as one, an oversized one as the maximum
  always_comb begin
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_DIM)) begin
      w_eff = DIM_W'(MAX_DIM);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_r > DIM_W'(MAX_DIM)) begin
      h_eff = DIM_W'(MAX_DIM);
    end else begin
      h_eff = height_r;
    end
  end

  assign accept   = in_valid && !in_stall;
  assign last_col = {1'b0, col_r} == (w_eff - DIM_W'(1));
  assign last_row = {1'b0, row_r} == (h_eff - DIM_W'(1));

  // a dimension write restarts the frame; otherwise advance on every beat
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    conj_nxt   = conj_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + COORD_W'(1);
      end else begin
        col_nxt = col_r + COORD_W'(1);
      end
    end
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          width_nxt = cfg_wdata;
          row_nxt   = '0;
          col_nxt   = '0;
        end
        REG_FRAME_HEIGHT: begin
          height_nxt = cfg_wdata;
          row_nxt    = '0;
          col_nxt    = '0;
        end
        REG_CONJUGATE_B: begin
          conj_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      conj_r   <= 1'b1;
      row_r    <= '0;
      col_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      conj_r   <= conj_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Classify the beat: lone real, first half of a pair (hold), or second half
  // --------------------------------------------------------------------------
  elem_t held_row_r, held_first_r, held_last_r;
  elem_t in_elem, partner;
  logic  first_edge, last_edge, edge_col, lone_row;
  kind_t kind0;

  assign in_elem    = '{a: in_a_value, b: in_b_value};
  assign first_edge = col_r == '0;
  assign last_edge  = !w_eff[0] && last_col;
  assign edge_col   = first_edge || last_edge;
  assign lone_row   = (row_r == '0) || (row_r[0] && last_row);
  assign partner    = !edge_col ? held_row_r : (first_edge ? held_first_r : held_last_r);

  always_comb begin
    if (edge_col) begin
      if (lone_row) begin
        kind0 = KIND_LONE;
      end else if (row_r[0]) begin
        kind0 = KIND_NONE;
      end else begin
        kind0 = KIND_PAIR;
      end
    end else if (col_r[0]) begin
      kind0 = KIND_NONE;
    end else begin
      kind0 = KIND_PAIR;
    end
  end

  // hold the real half of a pair in the slot that matches its column
  always_ff @(posedge clk) begin
    if (accept && kind0 == KIND_NONE) begin
      if (!edge_col) begin
        held_row_r <= in_elem;
      end else if (first_edge) begin
        held_first_r <= in_elem;
      end else begin
        held_last_r <= in_elem;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: operand register
  // --------------------------------------------------------------------------
  kind_t                    s1_kind_r;
  logic signed [DATA_W-1:0] s1_ra_r, s1_rb_r, s1_ia_r;
  logic signed [NEG_W-1:0]  s1_ib_r;
  logic [COORD_W-1:0]       s1_row0_r, s1_col0_r, s1_row1_r, s1_col1_r;
  logic                     s1_last_r;
  logic signed [NEG_W-1:0]  b_ext, ib_adj;

  assign b_ext  = NEG_W'(in_b_value);
  assign ib_adj = conj_r ? -b_ext : b_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_kind_r <= KIND_NONE;
    end else begin
      s1_kind_r <= accept ? kind0 : KIND_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (kind0 == KIND_LONE) begin
        s1_ra_r <= in_a_value;
        s1_rb_r <= in_b_value;
        s1_ia_r <= '0;
        s1_ib_r <= '0;
      end else begin
        s1_ra_r <= partner.a;
        s1_rb_r <= partner.b;
        s1_ia_r <= in_a_value;
        s1_ib_r <= ib_adj;
      end
      // real part sits one row up (edge column) or one column left
      s1_row0_r <= (edge_col && !lone_row) ? row_r - COORD_W'(1) : row_r;
      s1_col0_r <= edge_col ? col_r : col_r - COORD_W'(1);
      s1_row1_r <= row_r;
      s1_col1_r <= col_r;
      s1_last_r <= last_row && last_col;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: product register, four multipliers side by side
  // --------------------------------------------------------------------------
  kind_t                    s2_kind_r;
  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic [COORD_W-1:0]       s2_row0_r, s2_col0_r, s2_row1_r, s2_col1_r;
  logic                     s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_kind_r <= KIND_NONE;
    end else begin
      s2_kind_r <= s1_kind_r;
    end
  end

  always_ff @(posedge clk) begin
    p_rr_r    <= PROD_W'(s1_ra_r) * PROD_W'(s1_rb_r);
    p_ii_r    <= PROD_W'(s1_ia_r) * PROD_W'(s1_ib_r);
    p_ri_r    <= PROD_W'(s1_ra_r) * PROD_W'(s1_ib_r);
    p_ir_r    <= PROD_W'(s1_rb_r) * PROD_W'(s1_ia_r);
    s2_row0_r <= s1_row0_r;
    s2_col0_r <= s1_col0_r;
    s2_row1_r <= s1_row1_r;
    s2_col1_r <= s1_col1_r;
    s2_last_r <= s1_last_r;
  end

  // combine, round down, clamp; a lone real only uses the first product
  logic signed [SUM_W-1:0] sum_re, sum_im;
  result_t                 res0, res1;
  logic                    s2_lone;

  assign s2_lone = s2_kind_r == KIND_LONE;
  assign sum_re  = s2_lone ? SUM_W'(p_rr_r) : SUM_W'(p_rr_r) - SUM_W'(p_ii_r);
  assign sum_im  = SUM_W'(p_ri_r) + SUM_W'(p_ir_r);

  always_comb begin
    res0.row        = s2_row0_r;
    res0.col        = s2_col0_r;
    res0.value      = sat_q(sum_re);
    res0.run_last   = s2_lone;
    res0.frame_done = s2_lone && s2_last_r;
    res1.row        = s2_row1_r;
    res1.col        = s2_col1_r;
    res1.value      = sat_q(sum_im);
    res1.run_last   = 1'b1;
    res1.frame_done = s2_last_r;
  end

  // --------------------------------------------------------------------------
  // Result queue: up to two writes, one read per cycle
  // --------------------------------------------------------------------------
  result_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r, count_nxt;
  logic [1:0]           n_push, n_s1;
  logic                 pop;
  logic [OCC_W-1:0]     occupancy;
  result_t              head;

  assign n_push = kind_count(s2_kind_r);
  assign n_s1   = kind_count(s1_kind_r);
  assign pop    = out_valid && !out_stall;

  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  assign count_nxt  = count_r + FIFO_CW'(n_push) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (s2_kind_r == KIND_PAIR) begin
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= res1;
    end
  end

  // stall unless the queue can absorb everything in flight plus a pair
  assign occupancy = OCC_W'(count_r) + OCC_W'(n_s1) + OCC_W'(n_push);
  assign in_stall  = occupancy > OCC_W'(FIFO_DEPTH - 2);

  assign head              = fifo_r[rd_ptr_r];
  assign out_valid         = count_r != '0;
  assign out_row           = head.row;
  assign out_col           = head.col;
  assign out_product_value = head.value;
  assign out_run_last      = head.run_last;
  assign out_frame_done    = head.frame_done;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) == count_r[FIFO_AW-1:0])
    else $error("queue pointers disagree with count");

  a_raster_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < w_eff) && ({1'b0, row_r} < h_eff))
    else $error("raster position outside frame");

  a_pair_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    s1_kind_r == KIND_PAIR |->
      (s1_row0_r == s1_row1_r && s1_col0_r + COORD_W'(1) == s1_col1_r) ||
      (s1_col0_r == s1_col1_r && s1_row0_r + COORD_W'(1) == s1_row1_r))
    else $error("pair halves not adjacent");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_run_last)
    else $error("frame end flagged on a non-final result");

endmodule

// ===== tb/sv/psm_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// psm_checker: product predictor and scoreboard for packed_spectrum_multiply
// Follows the configuration port and both beat channels, predicts every
// product from its own raster counters and held pair halves, and compares
// each delivered result with the oldest prediction still waiting.
// ============================================================================
module psm_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [psm_pkg::DATA_W-1:0] in_a_value,
  input  logic signed [psm_pkg::DATA_W-1:0] in_b_value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [psm_pkg::COORD_W-1:0]       out_row,
  input  logic [psm_pkg::COORD_W-1:0]       out_col,
  input  logic signed [psm_pkg::DATA_W-1:0] out_product_value,
  input  logic                              out_run_last,
  input  logic                              out_frame_done,
  input  logic                              cfg_we,
  input  psm_pkg::cfg_idx_t                 cfg_index,
  input  logic [psm_pkg::DIM_W-1:0]         cfg_wdata,
  output int                                mismatches,
  output int                                products_owed
);
  import psm_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // wide enough for the exact sum of two 32 x 33 bit products
  typedef logic signed [SUM_W-1:0] wide_t;

  localparam wide_t Q_MAX = wide_t'(32'sh7fff_ffff);
  localparam wide_t Q_MIN = -Q_MAX - wide_t'(1);

  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;
  logic             conj_q;
  int               row_q;
  int               col_q;
  elem_t            held_row;
  elem_t            held_first;
  elem_t            held_last;
  result_t          expected_products [$];
  int               error_total = 0;

  function automatic int dim_in_use(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  // drop the fraction bits (floor) and clamp to the 32-bit range
  function automatic logic signed [DATA_W-1:0] to_q16(input wide_t x);
    wide_t q;
    q = x >>> FRAC_BITS;
    if (q > Q_MAX) q = Q_MAX;
    else if (q < Q_MIN) q = Q_MIN;
    return q[DATA_W-1:0];
  endfunction

  task automatic pair_parts(input elem_t first,
                            input logic signed [DATA_W-1:0] ia, ib,
                            output logic signed [DATA_W-1:0] re, im);
    wide_t ra, rb, xa, xb;
    ra = $signed(first.a);
    rb = $signed(first.b);
    xa = ia;
    xb = conj_q ? -wide_t'(ib) : wide_t'(ib);
    re = to_q16(ra * rb - xa * xb);
    im = to_q16(ra * xb + rb * xa);
  endtask

  function automatic result_t product_at(input int r, c,
                                         input logic signed [DATA_W-1:0] v);
    result_t res;
    res.row        = COORD_W'(r);
    res.col        = COORD_W'(c);
    res.value      = v;
    res.run_last   = 1'b0;
    res.frame_done = 1'b0;
    return res;
  endfunction

  task automatic apply_write(input cfg_idx_t idx, input logic [DIM_W-1:0] data);
    case (idx)
      REG_FRAME_WIDTH: begin
        width_q = data;
        row_q   = 0;
        col_q   = 0;
      end
      REG_FRAME_HEIGHT: begin
        height_q = data;
        row_q    = 0;
        col_q    = 0;
      end
      REG_CONJUGATE_B: conj_q = data[0];
      default: ;
    endcase
  endtask

  task automatic predict_products(input logic signed [DATA_W-1:0] a, b);
    int                       w, h, r, c, n;
    logic                     frame_end, edge_col;
    logic signed [DATA_W-1:0] re, im;
    elem_t                    cur;
    wide_t                    wa, wb;
    result_t                  made [2];
    w         = dim_in_use(width_q);
    h         = dim_in_use(height_q);
    r         = row_q;
    c         = col_q;
    cur.a     = a;
    cur.b     = b;
    wa        = a;
    wb        = b;
    frame_end = (r == h - 1) && (c == w - 1);
    edge_col  = (c == 0) || ((w % 2 == 0) && (c == w - 1));
    n         = 0;
    if (edge_col) begin
      // edge columns pair vertically; row 0 and a trailing odd row stand alone
      if (r == 0 || (r % 2 == 1 && r + 1 >= h)) begin
        made[0] = product_at(r, c, to_q16(wa * wb));
        n = 1;
      end else if (r % 2 == 1) begin
        if (c == 0) held_first = cur;
        else held_last = cur;
      end else begin
        pair_parts(c == 0 ? held_first : held_last, a, b, re, im);
        made[0] = product_at(r - 1, c, re);
        made[1] = product_at(r, c, im);
        n = 2;
      end
    end else if (c % 2 == 1) begin
      held_row = cur;
    end else begin
      pair_parts(held_row, a, b, re, im);
      made[0] = product_at(r, c - 1, re);
      made[1] = product_at(r, c, im);
      n = 2;
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) begin
        made[k].run_last   = 1'b1;
        made[k].frame_done = frame_end;
      end
      expected_products = {expected_products, made[k]};
    end
    if (c + 1 >= w) begin
      col_q = 0;
      row_q = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_q = c + 1;
    end
  endtask

  task automatic log_error(input string msg);
    error_total++;
    if (error_total <= REPORT_LIMIT) $display("%s", msg);
  endtask

  task automatic check_product();
    result_t got, want;
    got.row        = out_row;
    got.col        = out_col;
    got.value      = out_product_value;
    got.run_last   = out_run_last;
    got.frame_done = out_frame_done;
    if (expected_products.size() == 0) begin
      log_error($sformatf("unexpected product: row %0d col %0d value %0d last %0b done %0b",
                          got.row, got.col, got.value, got.run_last, got.frame_done));
      return;
    end
    want = expected_products.pop_front();
    if (got !== want) begin
      log_error($sformatf({"product mismatch: expected row %0d col %0d value %0d",
                           " last %0b done %0b, got row %0d col %0d value %0d",
                           " last %0b done %0b"},
                          want.row, want.col, want.value, want.run_last,
                          want.frame_done, got.row, got.col, got.value,
                          got.run_last, got.frame_done));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_q    = WIDTH_RESET;
      height_q   = HEIGHT_RESET;
      conj_q     = 1'b1;
      row_q      = 0;
      col_q      = 0;
      held_row   = '0;
      held_first = '0;
      held_last  = '0;
      expected_products.delete();
    end else begin
      if (cfg_we) apply_write(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) predict_products(in_a_value, in_b_value);
      if (out_valid && !out_stall) check_product();
    end
    mismatches    <= error_total;
    products_owed <= expected_products.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench: stimulus and verdict for packed_spectrum_multiply
// Drives raster beats of two packed spectra through a handful of frame
// settings, idles and stalls both channels at random, and leaves all
// prediction and comparison to the checker that sits beside the block.
// ============================================================================
module testbench;
  import psm_pkg::*;

  localparam int       RANDOM_BEATS    = 380;
  localparam int       SETTLE_CYCLES   = 8;    // covers the pipeline
  localparam int       HOLD_OFF_CYCLES = 300;  // long receiver hold-off
  localparam int       PRESSURE_BEATS  = 40;   // beats offered into the hold-off
  localparam cfg_idx_t REG_SPARE       = cfg_idx_t'(3);

  localparam logic signed [DATA_W-1:0] Q_TOP    = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_BOTTOM = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE    = 32'sh0001_0000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_a_value;
  logic signed [DATA_W-1:0] in_b_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [COORD_W-1:0]       out_row;
  logic [COORD_W-1:0]       out_col;
  logic signed [DATA_W-1:0] out_product_value;
  logic                     out_run_last;
  logic                     out_frame_done;
  logic                     cfg_we;
  cfg_idx_t                 cfg_index;
  logic [DIM_W-1:0]         cfg_wdata;

  int mismatches;
  int products_owed;
  int beats_sent  = 0;
  bit steady_feed = 1'b0;   // phase runs with back-to-back beats
  bit pressure_armed = 1'b0;
  bit pressure_done = 1'b0;
  int span_w;               // columns in use, for sizing phases
  int span_h;               // rows in use

  packed_spectrum_multiply i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_a_value        (in_a_value),
    .in_b_value        (in_b_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_product_value (out_product_value),
    .out_run_last      (out_run_last),
    .out_frame_done    (out_frame_done),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  psm_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_a_value        (in_a_value),
    .in_b_value        (in_b_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_product_value (out_product_value),
    .out_run_last      (out_run_last),
    .out_frame_done    (out_frame_done),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatches        (mismatches),
    .products_owed     (products_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Mostly no gap, some short ones, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 2);
    if (roll < 96) return $urandom_range(3, 8);
    return $urandom_range(10, 40);
  endfunction

  // Corners first, then small Q16.16 values that stay clear of saturation,
  // then full-range noise so every bit toggles.
  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return Q_TOP;
      1:       return Q_BOTTOM;
      2:       return '0;
      3, 4:    return DATA_W'($urandom_range(0, 262143)) - 32'sd131072;
      5:       return $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] corner_value(input int k);
    case (k % 8)
      0:       return Q_TOP;
      1:       return Q_BOTTOM;
      2:       return '0;
      3:       return -32'sd1;
      4:       return Q_ONE;
      5:       return -Q_ONE;
      6:       return 32'sd1;
      default: return 32'sh4000_0000;
    endcase
  endfunction

  // Small frames most of the time; zero, the largest and beyond now and then.
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      2:       return DIM_W'(MAX_DIM);
      3:       return DIM_W'(MAX_DIM + 1);
      default: return DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic int usable_span(input logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > DIM_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  // Offer one beat and hold it until taken. Valid stays high across
  // back-to-back beats; drop it only when a gap comes first.
  task automatic send_beat(input logic signed [DATA_W-1:0] a, b);
    int gap;
    gap = steady_feed ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_a_value <= a;
    in_b_value <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // One register write, then cfg_we drops before the task returns, so writes never abut.
  task automatic write_reg(input cfg_idx_t idx, input logic [DIM_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every predicted product, then let a beat that
  // only opened a pair clear the pipeline too.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (products_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drain, maybe retune the frame, then stream a run of random elements.
  // Small frames run one or two whole frames plus a partial one so frame
  // ends and wraps come up often; big frames only get a short stretch.
  task automatic run_random_phase();
    logic [DIM_W-1:0] w, h;
    int               beats, frame_beats;
    wait_drained();
    w = pick_dim();
    h = pick_dim();
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_CONJUGATE_B, DIM_W'($urandom_range(0, 1)));
        span_w = usable_span(w);
        span_h = usable_span(h);
      end
      3: begin
        write_reg(REG_FRAME_WIDTH, w);
        span_w = usable_span(w);
      end
      4: write_reg(REG_CONJUGATE_B, DIM_W'($urandom_range(0, 1)));
      default: ;  // carry on from wherever the raster stands
    endcase
    if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, DIM_W'($urandom()));
    frame_beats = span_w * span_h;
    if (frame_beats <= 48)
      beats = frame_beats * $urandom_range(1, 2) + $urandom_range(0, frame_beats);
    else
      beats = $urandom_range(8, 40);
    steady_feed = ($urandom_range(0, 3) == 0);
    repeat (beats) send_beat(random_value(), random_value());
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall in stretches of varying character, and once hold off
  // long enough that the result queue fills and the block stalls its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int mode, span;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (pressure_armed && !pressure_done) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 9);
        span = $urandom_range(10, 50);
        for (int i = 0; i < span; i++) begin
          // cut the stretch short once the sender asks for the hold-off
          if (pressure_armed && !pressure_done) break;
          case (mode)
            0, 1, 2, 3: out_stall <= 1'b0;                          // free flow
            8:          out_stall <= 1'b1;                          // long stall
            9:          out_stall <= (i < 3);                       // short blip
            default:    out_stall <= ($urandom_range(0, 99) < 35);  // choppy
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int directed_total;
    in_valid   <= 1'b0;
    in_a_value <= '0;
    in_b_value <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_FRAME_WIDTH;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    span_w = 1920;
    span_h = 1080;

    // Reset settings (1920 x 1080, conjugate on): lone real at the origin
    // at full scale, then an interior pair with both extremes so the
    // negated B imaginary part needs its extra bit.
    send_beat(Q_TOP, Q_TOP);
    send_beat(Q_BOTTOM, Q_TOP);
    send_beat(Q_BOTTOM, Q_BOTTOM);
    // leave a pair half held; the width write below restarts the frame
    send_beat(-Q_ONE, Q_ONE);
    wait_drained();

    // One whole 4 x 4 frame without conjugation: lone reals in both even
    // edge columns at row 0 and at the trailing odd row, vertical pairs in
    // between, horizontal pairs inside, and the frame end flag.
    write_reg(REG_FRAME_WIDTH, DIM_W'(4));
    write_reg(REG_FRAME_HEIGHT, DIM_W'(4));
    write_reg(REG_CONJUGATE_B, DIM_W'(0));
    span_w = 4;
    span_h = 4;
    for (int k = 0; k < 16; k++) send_beat(corner_value(k), corner_value(3 * k + 1));
    wait_drained();

    // Zero width acts as one column, an oversized height clamps to the
    // maximum; an unknown register index must be ignored.
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '1);
    write_reg(REG_CONJUGATE_B, DIM_W'(1));
    write_reg(REG_SPARE, DIM_W'(5));
    span_w = 1;
    span_h = MAX_DIM;
    repeat (3) send_beat(random_value(), random_value());

    // Ask the receiver for its long hold-off and keep offering beats back
    // to back, so the queue fills and the block stalls its input.
    pressure_armed = 1'b1;
    steady_feed    = 1'b1;
    repeat (PRESSURE_BEATS) send_beat(random_value(), random_value());
    steady_feed    = 1'b0;

    directed_total = beats_sent;
    while (beats_sent < directed_total + RANDOM_BEATS) run_random_phase();

    wait_drained();
    if (mismatches == 0 && products_owed == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
